FILE: rtl/ptfd_pkg.sv
// Package for the PWM timer frequency and duty setup block.
// Holds operation codes, limits and the shared divider widths.
// No dependencies.
package ptfd_pkg;

  localparam int DefMaxChannels = 4;

  localparam int DivNW   = 32;
  localparam int DivDW   = 18;
  localparam int DivCntW = 6;

  localparam logic [2:0] OP_SET_FREQ   = 3'd0;
  localparam logic [2:0] OP_SET_DUTY   = 3'd1;
  localparam logic [2:0] OP_SET_PULSE  = 3'd2;
  localparam logic [2:0] OP_SET_PERIOD = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;

  localparam logic [1:0] CFG_BUS_CLOCK = 2'd0;
  localparam logic [1:0] CFG_DOUBLED   = 2'd1;
  localparam logic [1:0] CFG_CHANNELS  = 2'd2;

  localparam logic [31:0] FreqLimit  = 32'd250000;
  localparam logic [31:0] TickMax    = 32'h0000_FFFF;
  localparam logic [7:0]  Hundred    = 8'd100;
  localparam logic [28:0] BusClkRst  = 29'd72000000;
  localparam logic [2:0]  ChanCntRst = 3'd4;

endpackage

FILE: rtl/ptfd_div.sv
// Restoring radix-2 divider shared by every division of the block.
// One quotient bit per cycle; depends on ptfd_pkg.
module ptfd_div
  import ptfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNW-1:0] dividend_i,
  input  logic [DivDW-1:0] divisor_i,
  output logic             done_o,
  output logic [DivNW-1:0] quot_o
);

  logic [DivCntW-1:0] cnt_q;
  logic [DivNW-1:0]   quo_q;
  logic [DivDW-1:0]   rem_q;
  logic [DivDW-1:0]   dvs_q;
  logic               done_q;
  logic [DivDW:0]     rem_sh;
  logic               ge;

  assign rem_sh = {rem_q, quo_q[DivNW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= DivCntW'(DivNW);
        quo_q <= dividend_i;
        rem_q <= '0;
        dvs_q <= divisor_i;
      end else if (cnt_q != '0) begin
        rem_q <= ge ? DivDW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DivDW-1:0];
        quo_q <= {quo_q[DivNW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(cnt_q) == DivCntW'(1)))
    else $error("divider done without a final step");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (cnt_q == '0))
    else $error("divider started while running");
  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && !start_i) |=> (cnt_q == $past(cnt_q) - DivCntW'(1)))
    else $error("divider count skipped");

endmodule

FILE: rtl/pwm_timer_frequency_duty_setup.sv
// PWM timer frequency and duty setup: register image plus operation sequencer.
// Uses ptfd_pkg and the shared divider ptfd_div.
//
// Usage: raise start_i with operation_i, channel_i and value_i while busy_o is
// low; the word is taken at that edge and busy_o rises. When the operation is
// done, valid_o is high for exactly one cycle together with ok_o, answer_o and
// the register image (prescaler, reload, addressed compare and its duty).
// busy_o is low again in that same cycle, so the next word may follow at once.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the
// user must do so only while idle, which the block itself does not enforce.
// Index 0 is the bus clock, 1 the doubling flag, 2 the channel count. Every
// division runs on one restoring divider at one bit per cycle. Pulse, period
// and read need no division but a duty readback. Set duty adds one division.
// Set frequency needs two divisions, two per active channel and the readback.
// Reset clears the prescaler, reload and compare registers to zero and loads
// the configuration defaults. The receiver cannot stall: each result is shown
// for one cycle only.
module pwm_timer_frequency_duty_setup
  import ptfd_pkg::*;
#(
  parameter int MAX_CHANNELS = DefMaxChannels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  operation_i,
  input  logic [3:0]  channel_i,
  input  logic [31:0] value_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [28:0] cfg_data_i,
  output logic        valid_o,
  output logic        ok_o,
  output logic [15:0] answer_o,
  output logic [15:0] prescaler_now_o,
  output logic [15:0] reload_now_o,
  output logic [15:0] channel_pulse_o,
  output logic [7:0]  channel_duty_o
);

  localparam int IdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CntW = $clog2(MAX_CHANNELS + 1);
  localparam logic [2:0] MaxCh = 3'(MAX_CHANNELS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TOT   = 4'd1;
  localparam logic [3:0] S_PER   = 4'd2;
  localparam logic [3:0] S_OLDGO = 4'd3;
  localparam logic [3:0] S_OLD   = 4'd4;
  localparam logic [3:0] S_NEWGO = 4'd5;
  localparam logic [3:0] S_NEW   = 4'd6;
  localparam logic [3:0] S_DSET  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]       state_q;
  logic [28:0]      bus_clk_q;
  logic             dbl_q;
  logic [2:0]       chan_cnt_q;
  logic [15:0]      presc_q;
  logic [15:0]      reload_q;
  logic [15:0]      cc_q   [MAX_CHANNELS];
  logic [7:0]       duty_q [MAX_CHANNELS];
  logic [3:0]       ch_q;
  logic [CntW-1:0]  i_q;
  logic [15:0]      pre_q;
  logic [15:0]      period_q;
  logic             ok_q;
  logic [15:0]      ans_q;
  logic [15:0]      pulse_q;
  logic [7:0]       duty_out_q;
  logic             valid_q;
  logic             go_q;
  logic [DivNW-1:0] div_n_q;
  logic [DivDW-1:0] div_d_q;

  logic             div_done;
  logic [DivNW-1:0] quot;
  logic [2:0]       act;
  logic [CntW-1:0]  n_ch;
  logic             chv;
  logic             chv_in;
  logic [3:0]       chm1;
  logic [3:0]       in_m1;
  logic [IdxW-1:0]  ch_idx;
  logic [IdxW-1:0]  in_idx;
  logic [IdxW-1:0]  i_idx;
  logic [IdxW-1:0]  rd_idx;
  logic [15:0]      cc_rd;
  logic [7:0]       dclamp;
  logic [15:0]      mul_a;
  logic [7:0]       mul_b;
  logic [23:0]      prod;
  logic [32:0]      pre_sum;
  logic [16:0]      pre_c;
  logic [29:0]      tclk;
  logic             accept;
  logic             last_ch;

  assign accept  = start_i && (state_q == S_IDLE);
  assign act     = (chan_cnt_q > MaxCh) ? MaxCh : chan_cnt_q;
  assign n_ch    = CntW'(act);
  assign chv     = (ch_q != 4'd0) && (ch_q <= {1'b0, act});
  assign chv_in  = (channel_i != 4'd0) && (channel_i <= {1'b0, act});
  assign chm1    = ch_q - 4'd1;
  assign in_m1   = channel_i - 4'd1;
  assign ch_idx  = chm1[IdxW-1:0];
  assign in_idx  = in_m1[IdxW-1:0];
  assign i_idx   = i_q[IdxW-1:0];
  assign rd_idx  = (state_q == S_OLDGO) ? i_idx : ch_idx;
  assign cc_rd   = cc_q[rd_idx];
  assign dclamp  = (value_i > 32'(Hundred)) ? Hundred : value_i[7:0];
  assign pre_sum = {1'b0, quot} + 33'h0_0000_FFFF;
  assign pre_c   = pre_sum[32:16];
  assign tclk    = dbl_q ? {bus_clk_q, 1'b0} : {1'b0, bus_clk_q};
  assign last_ch = CntW'(i_q + 1'b1) >= n_ch;

  // One multiplier, its operands picked by the step that launches a division.
  always_comb begin
    case (state_q)
      S_IDLE: begin
        mul_a = reload_q;
        mul_b = dclamp;
      end
      S_NEWGO: begin
        mul_a = period_q;
        mul_b = duty_q[i_idx];
      end
      default: begin
        mul_a = cc_rd;
        mul_b = Hundred;
      end
    endcase
  end
  assign prod = 24'(mul_a) * 24'(mul_b);

  ptfd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (go_q),
    .dividend_i (div_n_q),
    .divisor_i  (div_d_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_clk_q  <= BusClkRst;
      dbl_q      <= 1'b0;
      chan_cnt_q <= ChanCntRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BUS_CLOCK: bus_clk_q  <= cfg_data_i;
        CFG_DOUBLED:   dbl_q      <= cfg_data_i[0];
        CFG_CHANNELS:  chan_cnt_q <= cfg_data_i[2:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      presc_q    <= '0;
      reload_q   <= '0;
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        cc_q[k]   <= '0;
        duty_q[k] <= '0;
      end
      ch_q       <= '0;
      i_q        <= '0;
      pre_q      <= '0;
      period_q   <= '0;
      ok_q       <= 1'b0;
      ans_q      <= '0;
      pulse_q    <= '0;
      duty_out_q <= '0;
      valid_q    <= 1'b0;
      go_q       <= 1'b0;
      div_n_q    <= '0;
      div_d_q    <= '0;
    end else begin
      valid_q <= 1'b0;
      go_q    <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            ch_q    <= channel_i;
            ok_q    <= 1'b0;
            ans_q   <= '0;
            state_q <= S_FIN;
            case (operation_i)
              OP_SET_FREQ: begin
                if (value_i != 32'd0 && value_i <= FreqLimit) begin
                  go_q    <= 1'b1;
                  div_n_q <= DivNW'(tclk);
                  div_d_q <= value_i[DivDW-1:0];
                  state_q <= S_TOT;
                end
              end
              OP_SET_DUTY: begin
                if (chv_in) begin
                  go_q    <= 1'b1;
                  div_n_q <= DivNW'(prod);
                  div_d_q <= DivDW'(Hundred);
                  state_q <= S_DSET;
                end
              end
              OP_SET_PULSE: begin
                if (chv_in && value_i <= TickMax) begin
                  cc_q[in_idx] <= value_i[15:0];
                  ok_q         <= 1'b1;
                  ans_q        <= value_i[15:0];
                end
              end
              OP_SET_PERIOD: begin
                if (value_i <= TickMax) begin
                  reload_q <= value_i[15:0];
                  ok_q     <= 1'b1;
                  ans_q    <= value_i[15:0];
                end
              end
              OP_READ: begin
                ok_q  <= 1'b1;
                ans_q <= reload_q;
              end
              default: ;
            endcase
          end
        end
        S_TOT: begin
          if (div_done) begin
            if (pre_c == 17'd0 || pre_c[16]) begin
              state_q <= S_FIN;
            end else begin
              pre_q   <= pre_c[15:0];
              go_q    <= 1'b1;
              div_n_q <= quot;
              div_d_q <= DivDW'(pre_c[15:0]);
              state_q <= S_PER;
            end
          end
        end
        S_PER: begin
          if (div_done) begin
            if (quot > TickMax) begin
              state_q <= S_FIN;
            end else begin
              period_q <= quot[15:0];
              i_q      <= '0;
              if (n_ch == '0) begin
                presc_q  <= pre_q - 16'd1;
                reload_q <= quot[15:0] - 16'd1;
                ok_q     <= 1'b1;
                ans_q    <= quot[15:0];
                state_q  <= S_FIN;
              end else begin
                state_q <= S_OLDGO;
              end
            end
          end
        end
        S_OLDGO: begin
          // Duty before the change uses the old reload plus one as tick count.
          go_q    <= 1'b1;
          div_n_q <= DivNW'(prod);
          div_d_q <= DivDW'({1'b0, reload_q} + 17'd1);
          state_q <= S_OLD;
        end
        S_OLD: begin
          if (div_done) begin
            duty_q[i_idx] <= quot[7:0];
            if (!last_ch) begin
              i_q     <= i_q + 1'b1;
              state_q <= S_OLDGO;
            end else begin
              presc_q  <= pre_q - 16'd1;
              reload_q <= period_q - 16'd1;
              ok_q     <= 1'b1;
              ans_q    <= period_q;
              i_q      <= '0;
              state_q  <= S_NEWGO;
            end
          end
        end
        S_NEWGO: begin
          go_q    <= 1'b1;
          div_n_q <= DivNW'(prod);
          div_d_q <= DivDW'(Hundred);
          state_q <= S_NEW;
        end
        S_NEW: begin
          if (div_done) begin
            cc_q[i_idx] <= quot[15:0];
            if (!last_ch) begin
              i_q     <= i_q + 1'b1;
              state_q <= S_NEWGO;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_DSET: begin
          if (div_done) begin
            cc_q[ch_idx] <= quot[15:0];
            ok_q         <= 1'b1;
            ans_q        <= quot[15:0];
            state_q      <= S_FIN;
          end
        end
        S_FIN: begin
          pulse_q <= chv ? cc_rd : 16'd0;
          if (chv && reload_q != 16'd0) begin
            go_q    <= 1'b1;
            div_n_q <= DivNW'(prod);
            div_d_q <= DivDW'(reload_q);
            state_q <= S_OUT;
          end else begin
            duty_out_q <= '0;
            valid_q    <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        S_OUT: begin
          if (div_done) begin
            duty_out_q <= quot[7:0];
            valid_q    <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign valid_o         = valid_q;
  assign ok_o            = ok_q;
  assign answer_o        = ans_q;
  assign prescaler_now_o = presc_q;
  assign reload_now_o    = reload_q;
  assign channel_pulse_o = pulse_q;
  assign channel_duty_o  = duty_out_q;

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result word shown while busy");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not start the sequencer");
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ok_o) |-> (answer_o == 16'd0))
    else $error("rejected word carries a nonzero answer");

endmodule

FILE: tb/pwm_timer_frequency_duty_setup_test.sv
// Self-checking test of the PWM timer frequency and duty setup block.
// Predicts every result word in the bench itself and checks it on valid_o.
// Depends on ptfd_pkg and the pwm_timer_frequency_duty_setup RTL.
module pwm_timer_frequency_duty_setup_test;
  import ptfd_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [15:0] answer;
    logic [15:0] prescaler;
    logic [15:0] reload;
    logic [15:0] pulse;
    logic [7:0]  duty;
  } timer_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [2:0]  operation_i = '0;
  logic [3:0]  channel_i = '0;
  logic [31:0] value_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [28:0] cfg_data_i = '0;
  logic        valid_o, ok_o;
  logic [15:0] answer_o, prescaler_now_o, reload_now_o, channel_pulse_o;
  logic [7:0]  channel_duty_o;

  pwm_timer_frequency_duty_setup dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor copy of the register image and configuration.
  logic [28:0] bus_hz;
  logic        doubled;
  logic [2:0]  chan_cnt;
  logic [15:0] pre_q, reload_q;
  logic [15:0] cmp_q [4];

  timer_word_t expected_words[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic int unsigned active_chans();
    return chan_cnt > 4 ? 4 : chan_cnt;
  endfunction

  function automatic timer_word_t predict_word(logic [2:0] op, logic [3:0] ch,
                                               logic [31:0] val);
    timer_word_t w;
    logic [31:0] clk, total, pre, period, d, ticks, pulse;
    logic [31:0] duty_keep [4];
    logic [63:0] pre64;
    bit chv;
    int unsigned n;
    w = '0;
    chv = (ch >= 1) && (ch <= active_chans());
    n = active_chans();
    case (op)
      OP_SET_FREQ: begin
        if (val != 0 && val <= FreqLimit) begin
          clk = 32'(bus_hz) << doubled;
          total = clk / val;
          pre64 = (64'(total) + 64'hFFFF) / 64'h10000;
          pre = pre64[31:0];
          if (pre != 0 && pre <= TickMax) begin
            period = total / pre;
            if (period <= TickMax) begin
              ticks = 32'(reload_q) + 1;
              for (int i = 0; i < n; i++)
                duty_keep[i] = cmp_q[i] != 0 ?
                    ((32'(cmp_q[i]) * 100) / ticks) & 32'hFF : 0;
              pre_q = 16'(pre - 1);
              reload_q = 16'(period - 1);
              for (int i = 0; i < n; i++)
                cmp_q[i] = 16'((period * duty_keep[i]) / 100);
              w.ok = 1'b1;
              w.answer = 16'(period);
            end
          end
        end
      end
      OP_SET_DUTY: if (chv) begin
        d = val > 100 ? 100 : val;
        cmp_q[ch-1] = 16'((32'(reload_q) * d) / 100);
        w.ok = 1'b1;
        w.answer = cmp_q[ch-1];
      end
      OP_SET_PULSE: if (chv && val <= TickMax) begin
        cmp_q[ch-1] = val[15:0];
        w.ok = 1'b1;
        w.answer = val[15:0];
      end
      OP_SET_PERIOD: if (val <= TickMax) begin
        reload_q = val[15:0];
        w.ok = 1'b1;
        w.answer = val[15:0];
      end
      OP_READ: begin
        w.ok = 1'b1;
        w.answer = reload_q;
      end
      default: ;
    endcase
    if (chv) begin
      pulse = cmp_q[ch-1];
      w.pulse = pulse[15:0];
      if (reload_q != 0) w.duty = 8'((pulse * 100) / reload_q);
    end
    w.prescaler = pre_q;
    w.reload = reload_q;
    return w;
  endfunction

  // Result checker: every strobe must match the oldest expected word.
  always @(posedge clk_i) begin
    timer_word_t e;
    if (rst_ni && valid_o) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (ok_o !== e.ok) begin
          $error("ok exp %0d got %0d", e.ok, ok_o); errors++;
        end
        if (answer_o !== e.answer) begin
          $error("answer exp %0d got %0d", e.answer, answer_o); errors++;
        end
        if (prescaler_now_o !== e.prescaler) begin
          $error("prescaler_now exp %0d got %0d", e.prescaler, prescaler_now_o);
          errors++;
        end
        if (reload_now_o !== e.reload) begin
          $error("reload_now exp %0d got %0d", e.reload, reload_now_o); errors++;
        end
        if (channel_pulse_o !== e.pulse) begin
          $error("channel_pulse exp %0d got %0d", e.pulse, channel_pulse_o);
          errors++;
        end
        if (channel_duty_o !== e.duty) begin
          $error("channel_duty exp %0d got %0d", e.duty, channel_duty_o); errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word in either direction.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  int burst_left = 0;

  // Start stays high across a burst so that it is driven once per time step.
  task automatic send_word(logic [2:0] op, logic [3:0] ch, logic [31:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i <= 1'b1;
    operation_i <= op;
    channel_i <= ch;
    value_i <= val;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_words.push_back(predict_word(op, ch, val));
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [28:0] data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BUS_CLOCK: bus_hz = data;
      CFG_DOUBLED:   doubled = data[0];
      CFG_CHANNELS:  chan_cnt = data[2:0];
      default: ;
    endcase
  endtask

  task automatic test_directed();
    send_word(OP_READ, 4'd0, 32'd0);
    send_word(OP_SET_DUTY, 4'd1, 32'd50);
    send_word(OP_SET_PERIOD, 4'd0, 32'hFFFF);
    send_word(OP_SET_PERIOD, 4'd0, 32'h10000);
    send_word(OP_SET_PULSE, 4'd1, 32'h8000);
    send_word(OP_SET_PULSE, 4'd4, 32'hFFFF);
    send_word(OP_SET_PULSE, 4'd2, 32'hFFFF_FFFF);
    send_word(OP_SET_PULSE, 4'd0, 32'd5);
    send_word(OP_SET_PULSE, 4'd15, 32'd5);
    send_word(OP_SET_DUTY, 4'd3, 32'hFFFF_FFFF);
    send_word(OP_SET_DUTY, 4'd2, 32'd0);
    send_word(OP_SET_FREQ, 4'd0, 32'd1000);
    send_word(OP_SET_FREQ, 4'd7, 32'd0);
    send_word(OP_SET_FREQ, 4'd0, 32'd250000);
    send_word(OP_SET_FREQ, 4'd0, 32'd250001);
    send_word(OP_SET_FREQ, 4'd0, 32'd1);
    send_word(OP_SET_DUTY, 4'd1, 32'd33);
    send_word(OP_SET_FREQ, 4'd0, 32'd20000);
    send_word(3'd5, 4'd1, 32'd1);
    send_word(3'd7, 4'd1, 32'hFFFF_FFFF);
    send_word(OP_READ, 4'd15, 32'hFFFF_FFFF);
  endtask

  task automatic test_random(int count);
    logic [2:0] op;
    logic [31:0] val;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          op = OP_SET_FREQ;
          val = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 250000);
        end
        2, 3: begin
          op = OP_SET_DUTY;
          val = $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 100);
        end
        4, 5: begin
          op = OP_SET_PULSE;
          val = $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 16'hFFFF);
        end
        6, 7: begin
          op = OP_SET_PERIOD;
          val = $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 16'hFFFF);
        end
        8: begin op = OP_READ; val = $urandom; end
        default: begin op = 3'($urandom); val = $urandom; end
      endcase
      send_word(op, $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(1, 4)),
                val);
    end
  endtask

  task automatic test_config_sweep();
    write_cfg(CFG_BUS_CLOCK, 29'd1);
    test_random(40);
    write_cfg(CFG_BUS_CLOCK, 29'd500000000);
    write_cfg(CFG_DOUBLED, 29'd1);
    write_cfg(CFG_CHANNELS, 29'd1);
    test_random(120);
    write_cfg(CFG_CHANNELS, 29'd0);
    write_cfg(CFG_BUS_CLOCK, 29'h1FFF_FFFF);
    test_random(60);
    write_cfg(CFG_CHANNELS, 29'd7);
    write_cfg(CFG_BUS_CLOCK, 29'd8000000);
    write_cfg(CFG_DOUBLED, 29'd0);
    test_random(120);
    write_cfg(CFG_BUS_CLOCK, 29'($urandom_range(1, 500000000)));
    write_cfg(CFG_DOUBLED, 29'($urandom_range(0, 1)));
    write_cfg(CFG_CHANNELS, 29'($urandom_range(1, 4)));
    test_random(110);
  endtask

  initial begin
    bus_hz = BusClkRst;
    doubled = 1'b0;
    chan_cnt = ChanCntRst;
    pre_q = '0;
    reload_q = '0;
    for (int i = 0; i < 4; i++) cmp_q[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300);
    test_config_sweep();
    drain();
    repeat (400) @(posedge clk_i);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

FILE: pwm_timer_frequency_duty_setup.f
rtl/ptfd_pkg.sv
rtl/ptfd_div.sv
rtl/pwm_timer_frequency_duty_setup.sv
tb/pwm_timer_frequency_duty_setup_test.sv
